[hdl/rdfa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdfa_pkg
// Shared constants, types and the quarter-wave sine table of the running
// DFT field accumulator.
// ----------------------------------------------------------------------------
package rdfa_pkg;

  localparam int SURFACE_CELLS = 4096;
  localparam int PHASE_BITS    = 10;
  localparam int ACC_BITS      = 40;

  localparam int CELL_W  = 12;
  localparam int TIME_W  = 32;
  localparam int FREQ_W  = 32;
  localparam int SAMP_W  = 16;
  localparam int HSUM_W  = SAMP_W + 1;
  localparam int OUT_W   = 40;
  localparam int INC_W   = 17;
  localparam int CELL_AW = $clog2(SURFACE_CELLS);
  localparam int N_ACC   = 8;

  localparam int QDEPTH = 4;
  localparam int Q_AW   = $clog2(QDEPTH);

  localparam int QUARTER_STEPS = 1 << (PHASE_BITS - 2);
  localparam longint unsigned Q30_ONE     = 64'd1 << 30;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef logic [14:0] qsin_tab_t [0:QUARTER_STEPS];
  typedef logic signed [ACC_BITS-1:0] acc_t;
  typedef logic signed [SAMP_W-1:0] samp_t;
  typedef logic signed [HSUM_W-1:0] hsum_t;
  typedef logic [PHASE_BITS-1:0] phase_t;

  typedef struct packed {
    logic [CELL_W-1:0] cidx;
    logic              cell_ok;
    phase_t            ph_e;
    phase_t            ph_h;
    samp_t             e1;
    samp_t             e2;
    hsum_t             h1;
    hsum_t             h2;
  } q_ent_t;

  typedef struct packed {
    logic   push;
    q_ent_t ent;
  } q_wr_t;

  typedef struct packed {
    logic   full;
    logic   empty;
    q_ent_t head;
  } q_rd_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } bk_stat_t;

  function automatic qsin_tab_t build_qsin();
    qsin_tab_t       tab;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned q;
    for (int r = 0; r <= QUARTER_STEPS; r++) begin
      x  = (longint'(r) * HALF_PI_Q30) >> (PHASE_BITS - 2);
      x2 = (x * x) >> 30;
      t  = Q30_ONE - x2 / 72;
      t  = Q30_ONE - ((x2 * t) >> 30) / 42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 6;
      s  = (x * t) >> 30;
      q  = (s + 64'd16384) >> 15;
      if (q > 64'd32767) q = 64'd32767;
      tab[r] = q[14:0];
    end
    return tab;
  endfunction

  localparam qsin_tab_t QSIN = build_qsin();

  function automatic samp_t sine_at(phase_t idx);
    logic [1:0]            quad;
    logic [PHASE_BITS-2:0] r;
    logic [PHASE_BITS-2:0] rr;
    samp_t                 v;
    quad = idx[PHASE_BITS-1 -: 2];
    r    = {1'b0, idx[PHASE_BITS-3:0]};
    rr   = quad[0] ? ((PHASE_BITS-1)'(QUARTER_STEPS) - r) : r;
    v    = {1'b0, QSIN[rr]};
    return quad[1] ? -v : v;
  endfunction

  function automatic samp_t cosine_at(phase_t idx);
    return sine_at(idx + PHASE_BITS'(QUARTER_STEPS));
  endfunction

endpackage

[hdl/rdfa_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdfa_if
// Valid/ready channels for field sample beats and phasor sum beats.
// ----------------------------------------------------------------------------
interface rdfa_in_if;
  logic                                       valid;
  logic                                       ready;
  logic        [rdfa_pkg::CELL_W-1:0]         cell_index;
  logic        [rdfa_pkg::TIME_W-1:0]         time_e;
  logic        [rdfa_pkg::TIME_W-1:0]         time_h;
  logic signed [rdfa_pkg::SAMP_W-1:0]         e1_sample;
  logic signed [rdfa_pkg::SAMP_W-1:0]         e2_sample;
  logic signed [rdfa_pkg::SAMP_W-1:0]         h1_here;
  logic signed [rdfa_pkg::SAMP_W-1:0]         h1_next;
  logic signed [rdfa_pkg::SAMP_W-1:0]         h2_here;
  logic signed [rdfa_pkg::SAMP_W-1:0]         h2_next;

  modport source (output valid, cell_index, time_e, time_h, e1_sample, e2_sample,
                  h1_here, h1_next, h2_here, h2_next, input ready);
  modport sink (input valid, cell_index, time_e, time_h, e1_sample, e2_sample,
                h1_here, h1_next, h2_here, h2_next, output ready);
endinterface

interface rdfa_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [rdfa_pkg::OUT_W-1:0]  acc_e1_re;
  logic signed [rdfa_pkg::OUT_W-1:0]  acc_e1_im;
  logic signed [rdfa_pkg::OUT_W-1:0]  acc_e2_re;
  logic signed [rdfa_pkg::OUT_W-1:0]  acc_e2_im;
  logic signed [rdfa_pkg::OUT_W-1:0]  acc_h1_re;
  logic signed [rdfa_pkg::OUT_W-1:0]  acc_h1_im;
  logic signed [rdfa_pkg::OUT_W-1:0]  acc_h2_re;
  logic signed [rdfa_pkg::OUT_W-1:0]  acc_h2_im;

  modport source (output valid, acc_e1_re, acc_e1_im, acc_e2_re, acc_e2_im,
                  acc_h1_re, acc_h1_im, acc_h2_re, acc_h2_im, input ready);
  modport sink (input valid, acc_e1_re, acc_e1_im, acc_e2_re, acc_e2_im,
                acc_h1_re, acc_h1_im, acc_h2_re, acc_h2_im, output ready);
endinterface

[hdl/rdfa_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdfa_front
// Takes sample beats, forms both phase indexes and the H neighbour sums,
// and pushes one entry per beat into the queue.
// ----------------------------------------------------------------------------
module rdfa_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [rdfa_pkg::FREQ_W-1:0]  cfg_wdata,
  rdfa_in_if.sink                      in_bus,
  input  rdfa_pkg::bk_stat_t           stat,
  input  rdfa_pkg::q_rd_t              q_rd,
  output rdfa_pkg::q_wr_t              q_wr
);
  import rdfa_pkg::*;

  logic [FREQ_W-1:0] freq_r;
  logic              f_vld_r;
  logic              f_vld_nxt;
  q_ent_t            f_ent_r;
  logic [63:0]       pe_full;
  logic [63:0]       ph_full;
  logic              load;
  logic              push;

  assign pe_full = {32'd0, freq_r} * {32'd0, in_bus.time_e};
  assign ph_full = {32'd0, freq_r} * {32'd0, in_bus.time_h};

  assign push         = f_vld_r && !q_rd.full;
  assign in_bus.ready = !stat.clearing && (!f_vld_r || !q_rd.full);
  assign load         = in_bus.valid && in_bus.ready;

  always_comb begin
    f_vld_nxt = f_vld_r;
    if (load) begin
      f_vld_nxt = 1'b1;
    end else if (push) begin
      f_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
      freq_r  <= '0;
    end else begin
      f_vld_r <= f_vld_nxt;
      if (cfg_we) begin
        freq_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      f_ent_r.cidx    <= in_bus.cell_index;
      f_ent_r.cell_ok <= 32'(in_bus.cell_index) < 32'(SURFACE_CELLS);
      f_ent_r.ph_e    <= pe_full[31 -: PHASE_BITS];
      f_ent_r.ph_h    <= ph_full[31 -: PHASE_BITS];
      f_ent_r.e1      <= in_bus.e1_sample;
      f_ent_r.e2      <= in_bus.e2_sample;
      f_ent_r.h1      <= HSUM_W'(in_bus.h1_here) + HSUM_W'(in_bus.h1_next);
      f_ent_r.h2      <= HSUM_W'(in_bus.h2_here) + HSUM_W'(in_bus.h2_next);
    end
  end

  assign q_wr.push = push;
  assign q_wr.ent  = f_ent_r;

endmodule

[hdl/rdfa_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdfa_queue
// Short FIFO of classified entries between the front and the back.
// ----------------------------------------------------------------------------
module rdfa_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  rdfa_pkg::q_wr_t     q_wr,
  input  rdfa_pkg::bk_stat_t  stat,
  output rdfa_pkg::q_rd_t     q_rd
);
  import rdfa_pkg::*;

  q_ent_t          mem_r [QDEPTH];
  logic [Q_AW-1:0] wp_r;
  logic [Q_AW-1:0] rp_r;
  logic [Q_AW:0]   cnt_r;
  logic [Q_AW:0]   cnt_nxt;
  logic            do_pop;

  assign do_pop = stat.pop && (cnt_r != '0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (q_wr.push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!q_wr.push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (q_wr.push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= rp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      mem_r[wp_r] <= q_wr.ent;
    end
  end

  assign q_rd.full  = (cnt_r == (Q_AW+1)'(QDEPTH));
  assign q_rd.empty = (cnt_r == '0);
  assign q_rd.head  = mem_r[rp_r];

endmodule

[hdl/rdfa_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdfa_back
// Table lookup, rotation, saturating update of the cell store and the
// result register; also runs the store clearing pass after reset.
// ----------------------------------------------------------------------------
module rdfa_back (
  input  logic                clk,
  input  logic                rst_n,
  input  rdfa_pkg::q_rd_t     q_rd,
  output rdfa_pkg::bk_stat_t  stat,
  rdfa_out_if.source          out_bus
);
  import rdfa_pkg::*;

  localparam logic signed [ACC_BITS:0] ACC_MAX = (ACC_BITS+1)'((65'sd1 <<< (ACC_BITS-1)) - 1);
  localparam logic signed [ACC_BITS:0] ACC_MIN = -ACC_MAX - 1;

  logic [N_ACC*ACC_BITS-1:0] store [SURFACE_CELLS];

  logic               clr_r;
  logic [CELL_AW-1:0] clr_cnt_r;
  logic               adv;
  logic               pop;

  logic   b_vld_r;
  q_ent_t b_ent_r;

  logic               c_vld_r;
  logic [CELL_W-1:0]  c_cell_r;
  logic               c_ok_r;
  samp_t              c_ce_r, c_se_r, c_ch_r, c_sh_r;
  samp_t              c_e1_r, c_e2_r;
  hsum_t              c_h1_r, c_h2_r;

  logic                       d_vld_r;
  logic [CELL_W-1:0]          d_cell_r;
  logic                       d_ok_r;
  logic signed [31:0]         d_pe_r [4];
  logic signed [32:0]         d_ph_r [4];
  logic [N_ACC*ACC_BITS-1:0]  rd_r;

  logic              hist_vld_r;
  logic [CELL_W-1:0] hist_cell_r;
  logic              out_vld_r;
  acc_t              acc_r [N_ACC];

  logic signed [INC_W-1:0]    inc [N_ACC];
  logic signed [31:0]         pe_rnd [4];
  logic signed [32:0]         ph_rnd [4];
  acc_t                       old_v [N_ACC];
  logic signed [ACC_BITS:0]   sum [N_ACC];
  acc_t                       new_v [N_ACC];
  logic [N_ACC*ACC_BITS-1:0]  new_row;
  logic                       fwd;
  logic                       mem_we;
  logic [CELL_AW-1:0]         mem_wa;
  logic [N_ACC*ACC_BITS-1:0]  mem_wd;

  assign adv = !out_vld_r || out_bus.ready;
  assign pop = adv && !q_rd.empty && !clr_r;

  assign stat.pop      = pop;
  assign stat.clearing = clr_r;

  // clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == CELL_AW'(SURFACE_CELLS - 1)) begin
        clr_r <= 1'b0;
      end
    end
  end

  // control valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r    <= 1'b0;
      c_vld_r    <= 1'b0;
      d_vld_r    <= 1'b0;
      out_vld_r  <= 1'b0;
      hist_vld_r <= 1'b0;
    end else if (adv) begin
      b_vld_r    <= pop;
      c_vld_r    <= b_vld_r;
      d_vld_r    <= c_vld_r;
      out_vld_r  <= d_vld_r;
      hist_vld_r <= d_vld_r && d_ok_r;
    end
  end

  // queue head register and table lookup stage
  always_ff @(posedge clk) begin
    if (adv) begin
      b_ent_r  <= q_rd.head;
      c_cell_r <= b_ent_r.cidx;
      c_ok_r   <= b_ent_r.cell_ok;
      c_ce_r   <= cosine_at(b_ent_r.ph_e);
      c_se_r   <= sine_at(b_ent_r.ph_e);
      c_ch_r   <= cosine_at(b_ent_r.ph_h);
      c_sh_r   <= sine_at(b_ent_r.ph_h);
      c_e1_r   <= b_ent_r.e1;
      c_e2_r   <= b_ent_r.e2;
      c_h1_r   <= b_ent_r.h1;
      c_h2_r   <= b_ent_r.h2;
    end
  end

  // rotation multiplies and store read
  always_ff @(posedge clk) begin
    if (adv) begin
      d_cell_r  <= c_cell_r;
      d_ok_r    <= c_ok_r;
      d_pe_r[0] <= c_e1_r * c_ce_r;
      d_pe_r[1] <= c_e1_r * c_se_r;
      d_pe_r[2] <= c_e2_r * c_ce_r;
      d_pe_r[3] <= c_e2_r * c_se_r;
      d_ph_r[0] <= c_h1_r * c_ch_r;
      d_ph_r[1] <= c_h1_r * c_sh_r;
      d_ph_r[2] <= c_h2_r * c_ch_r;
      d_ph_r[3] <= c_h2_r * c_sh_r;
      rd_r      <= store[c_cell_r[CELL_AW-1:0]];
    end
  end

  // round, forward, saturate
  assign fwd = hist_vld_r && (hist_cell_r == d_cell_r);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      pe_rnd[k]   = d_pe_r[k] + 32'sd16384;
      ph_rnd[k]   = d_ph_r[k] + 33'sd32768;
      inc[k]      = INC_W'(pe_rnd[k] >>> 15);
      inc[k + 4]  = INC_W'(ph_rnd[k] >>> 16);
    end
    for (int k = 0; k < N_ACC; k++) begin
      old_v[k] = fwd ? acc_r[k] : acc_t'(rd_r[k*ACC_BITS +: ACC_BITS]);
      sum[k]   = (ACC_BITS+1)'(old_v[k]) + (ACC_BITS+1)'(inc[k]);
      if (sum[k] > ACC_MAX) begin
        new_v[k] = acc_t'(ACC_MAX);
      end else if (sum[k] < ACC_MIN) begin
        new_v[k] = acc_t'(ACC_MIN);
      end else begin
        new_v[k] = acc_t'(sum[k]);
      end
      new_row[k*ACC_BITS +: ACC_BITS] = new_v[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv && d_vld_r) begin
      hist_cell_r <= d_cell_r;
      for (int k = 0; k < N_ACC; k++) begin
        acc_r[k] <= d_ok_r ? new_v[k] : '0;
      end
    end
  end

  // store write port, shared with the clearing pass
  always_comb begin
    if (clr_r) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt_r;
      mem_wd = '0;
    end else begin
      mem_we = adv && d_vld_r && d_ok_r;
      mem_wa = d_cell_r[CELL_AW-1:0];
      mem_wd = new_row;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_wa] <= mem_wd;
    end
  end

  assign out_bus.valid     = out_vld_r;
  assign out_bus.acc_e1_re = OUT_W'(acc_r[0]);
  assign out_bus.acc_e1_im = OUT_W'(acc_r[1]);
  assign out_bus.acc_e2_re = OUT_W'(acc_r[2]);
  assign out_bus.acc_e2_im = OUT_W'(acc_r[3]);
  assign out_bus.acc_h1_re = OUT_W'(acc_r[4]);
  assign out_bus.acc_h1_im = OUT_W'(acc_r[5]);
  assign out_bus.acc_h2_re = OUT_W'(acc_r[6]);
  assign out_bus.acc_h2_im = OUT_W'(acc_r[7]);

endmodule

[hdl/running_dft_field_accumulator_core.sv]
`timescale 1ns / 1ps
// path: a sample beat passes the front register, queue, lookup, multiply
// and store update before its result beat is valid, later if queued
// throughput: one beat, store read and write per cycle; out_bus.ready stalls
// reset: after rst_n a clearing pass zeroes every cell of the cell store,
// in_bus.ready stays low meanwhile; the frequency register resets to zero
// ----------------------------------------------------------------------------
// running_dft_field_accumulator_core
// One-bin running DFT of tangential E and H samples per surface cell.
// ----------------------------------------------------------------------------
module running_dft_field_accumulator_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [rdfa_pkg::FREQ_W-1:0]  cfg_wdata,
  rdfa_in_if.sink                      in_bus,
  rdfa_out_if.source                   out_bus
);
  import rdfa_pkg::*;

  q_wr_t    q_wr;
  q_rd_t    q_rd;
  bk_stat_t stat;

  rdfa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_bus    (in_bus),
    .stat      (stat),
    .q_rd      (q_rd),
    .q_wr      (q_wr)
  );

  rdfa_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .q_wr  (q_wr),
    .stat  (stat),
    .q_rd  (q_rd)
  );

  rdfa_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_rd    (q_rd),
    .stat    (stat),
    .out_bus (out_bus)
  );

  a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    stat.clearing |-> !in_bus.ready)
    else $error("sample beat taken during clearing pass");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr.push |-> (!q_rd.full || stat.pop))
    else $error("queue push while full");

  a_no_out_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    stat.clearing |-> !out_bus.valid)
    else $error("result beat during clearing pass");

endmodule
